// ===== rtl/core/cdq_pkg.sv =====
`timescale 1ns / 1ps

package cdq_pkg;

  // Number of cells in the chain, one stored word each
  localparam int unsigned DEPTH  = 8;
  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One input transfer
  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] push_value;
  } in_t;

  // One result transfer
  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] popped_value;
    logic                     full_after;
    logic                     empty_after;
  } out_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic shift_right;  // push at the front: every cell takes its left neighbour
    logic shift_left;   // pop at the front: every cell takes its right neighbour
    logic fill;         // push at the rear: first empty cell takes the word
    logic drop;         // pop at the rear: last occupied cell empties
  } cmd_t;

endpackage

// ===== rtl/core/cdq_cell.sv =====
`timescale 1ns / 1ps

module cdq_cell import cdq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  input  word_t push_word,
  input  word_t lft_word,
  input  logic  lft_valid,
  input  word_t rgt_word,
  input  logic  rgt_valid,
  output word_t cell_word,
  output logic  cell_valid,
  output word_t rear_tap
);

  word_t word_r, word_nxt;
  logic  valid_r, valid_nxt;
  logic  at_rear;

  // This cell holds the rear entry when it is occupied and its right neighbour is not
  assign at_rear = valid_r && !rgt_valid;

  // Work out the next content from the command and the neighbours
  always_comb begin
    word_nxt  = word_r;
    valid_nxt = valid_r;
    priority if (cmd.shift_right) begin
      word_nxt  = lft_word;
      valid_nxt = lft_valid;
    end else if (cmd.shift_left) begin
      word_nxt  = rgt_word;
      valid_nxt = rgt_valid;
    end else if (cmd.fill) begin
      if (!valid_r && lft_valid) begin
        word_nxt  = push_word;
        valid_nxt = 1'b1;
      end
    end else if (cmd.drop) begin
      if (at_rear) begin
        valid_nxt = 1'b0;
      end
    end else begin
      // hold on an idle cycle
      word_nxt  = word_r;
      valid_nxt = valid_r;
    end
  end

  // Occupancy is control state and clears on reset; the word needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign cell_word  = word_r;
  assign cell_valid = valid_r;
  assign rear_tap   = at_rear ? word_r : '0;

endmodule

// ===== rtl/core/circular_deque_core.sv =====
`timescale 1ns / 1ps
// Double-ended queue of 32-bit words, DEPTH entries deep.
// Input: present in_item with start high; the transfer takes place at a rising
// edge where start is high and busy is low. in_item.op chooses push front,
// push rear, pop front or pop rear; push_value is the word to insert.
// Output: one result per input, shown on out_item for exactly one cycle with
// out_valid high. The result of an input taken at edge N appears in the
// cycle after edge N. Throughput: one operation per cycle; busy is always low.
// Each operation moves the whole row of cells by at most one place; a pop at
// the rear selects the rear cell through an OR tree over the row.
// A refused push (deque full) or pop (deque empty) leaves the contents
// unchanged and reports its status; popped_value is zero unless a pop succeeds.
// full_after and empty_after give the occupancy once the operation is done.
// Reset (rst_n low, synchronous) empties the deque and drops any pending
// result. The receiver cannot stall: a result must be taken in its cycle.
module circular_deque_core import cdq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  word_t       cell_word [DEPTH];
  word_t       rear_tap  [DEPTH];
  logic [DEPTH-1:0] cell_vld;

  cmd_t    cmd;
  logic    acc;
  logic    is_full;
  logic    is_empty;
  word_t   push_word;
  word_t   rear_word;
  word_t   pop_word;
  status_t status_nxt;

  logic    out_valid_r, out_valid_nxt;
  status_t status_r;
  word_t   popped_r, popped_nxt;

  // One operation per cycle, never held off
  assign busy      = 1'b0;
  assign acc       = start && !busy;
  assign push_word = word_t'(in_item.push_value);
  assign is_full   = cell_vld[DEPTH-1];
  assign is_empty  = !cell_vld[0];

  // Decode the operation into a chain command and a status
  always_comb begin
    cmd        = '0;
    status_nxt = ST_DONE;
    unique case (in_item.op)
      OP_PUSH_FRONT: begin
        cmd.shift_right = acc && !is_full;
        if (is_full) status_nxt = ST_FULL;
      end
      OP_PUSH_REAR: begin
        cmd.fill = acc && !is_full;
        if (is_full) status_nxt = ST_FULL;
      end
      OP_POP_FRONT: begin
        cmd.shift_left = acc && !is_empty;
        if (is_empty) status_nxt = ST_EMPTY;
      end
      OP_POP_REAR: begin
        cmd.drop = acc && !is_empty;
        if (is_empty) status_nxt = ST_EMPTY;
      end
      default: begin
        cmd        = '0;
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Build the row of cells; the front end feeds the push word in
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t lft_w, rgt_w;
    logic  lft_v, rgt_v;

    if (g == 0) begin : g_front
      assign lft_w = push_word;
      assign lft_v = 1'b1;
    end else begin : g_inner_l
      assign lft_w = cell_word[g-1];
      assign lft_v = cell_vld[g-1];
    end

    if (g == DEPTH - 1) begin : g_back
      assign rgt_w = '0;
      assign rgt_v = 1'b0;
    end else begin : g_inner_r
      assign rgt_w = cell_word[g+1];
      assign rgt_v = cell_vld[g+1];
    end

    cdq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .push_word  (push_word),
      .lft_word   (lft_w),
      .lft_valid  (lft_v),
      .rgt_word   (rgt_w),
      .rgt_valid  (rgt_v),
      .cell_word  (cell_word[g]),
      .cell_valid (cell_vld[g]),
      .rear_tap   (rear_tap[g])
    );
  end

  // Collect the rear word: at most one cell drives a non-zero tap
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | rear_tap[i];
    end
  end

  // Select the popped word; zero unless a pop goes through
  always_comb begin
    pop_word   = '0;
    popped_nxt = '0;
    if (in_item.op == OP_POP_FRONT) begin
      pop_word = cell_word[0];
    end else begin
      pop_word = rear_word;
    end
    if (cmd.shift_left || cmd.drop) begin
      popped_nxt = pop_word;
    end
  end

  assign out_valid_nxt = acc;

  // Hold the result for its one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
  end

  // Occupancy flags come straight from the cells, which hold the new state
  assign out_valid             = out_valid_r;
  assign out_item.status       = status_r;
  assign out_item.popped_value = signed'(popped_r);
  assign out_item.full_after   = cell_vld[DEPTH-1];
  assign out_item.empty_after  = !cell_vld[0];

`ifndef SYNTHESIS
  // Occupied cells always form an unbroken run from the front
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_vld >> 1) & ~cell_vld) == '0)
    else $error("deque cells not contiguous");

  // A refused push leaves the deque full
  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |-> out_item.full_after)
    else $error("push refused but deque not full");

  // A refused pop leaves the deque empty
  a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_EMPTY |-> out_item.empty_after)
    else $error("pop refused but deque not empty");

  // A refused operation returns no word
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_DONE |-> out_item.popped_value == '0)
    else $error("refused operation returned a word");

  // A successful push makes the deque non-empty
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_right || cmd.fill |=> cell_vld[0])
    else $error("push left the deque empty");
`endif

endmodule
